// ----- rtl/core/hcsb_pkg.sv -----
// Package with the shared types, character codes and helpers of the hex command shift bridge.
`default_nettype none

package hcsb_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		ACT_TX        = 2'd0,
		ACT_PINS      = 2'd1,
		ACT_SHIFT_OUT = 2'd2,
		ACT_SHIFT_IN  = 2'd3
	} action_t;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_BANG    = 8'h21;
	localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
	localparam logic [7:0] CHAR_GREATER = 8'h3E;
	localparam logic [7:0] CHAR_LESS    = 8'h3C;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;

	localparam logic [3:0] DIGITS_WORD = 4'd8;
	localparam logic [3:0] DIGITS_HALF = 4'd4;
	localparam logic [3:0] DIGITS_BYTE = 4'd2;

	typedef struct packed {
		logic [7:0]  rx_char;
		logic [31:0] target_bits;
	} item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  tx_char;
		logic        port_select;
		logic        reset_level;
		logic        clock_level;
		logic        data_level;
		logic [31:0] shift_word;
		logic [5:0]  shift_length;
		logic        last;
	} result_t;

	typedef struct packed {
		action_t     kind;
		logic [7:0]  ch;
		logic        port;
		logic        rst;
		logic        clk;
		logic        dat;
		logic [31:0] word;
		logic [5:0]  length;
		logic [3:0]  digits;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] n8;
		n8 = {4'b0000, nib};
		if (nib > 4'd9) begin
			return n8 + CHAR_UPPER_A - 8'd10;
		end
		return n8 + CHAR_ZERO;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hcsb_front.sv -----
// Front end: accepts characters, updates the accumulator, data word and port, and queues commands.
`default_nettype none

module hcsb_front
	import hcsb_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	input  wire logic  queue_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [31:0] acc_q;
	logic [31:0] data_q;
	logic        sel_q;
	logic [31:0] acc_d;
	logic [31:0] data_d;
	logic        sel_d;
	logic        push_c;
	logic        accept;
	logic [7:0]  ch;
	logic [4:0]  len5;
	logic [31:0] captured;

	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;
	assign push       = accept && push_c;
	assign ch         = item.rx_char;
	assign len5       = acc_q[4:0];
	assign captured   = item.target_bits & ~(32'hFFFF_FFFF << len5);

	always_comb begin
		acc_d           = acc_q;
		data_d          = data_q;
		sel_d           = sel_q;
		push_c          = 1'b1;
		push_cmd        = '0;
		push_cmd.kind   = ACT_TX;
		push_cmd.ch     = ch;
		push_cmd.port   = sel_q;
		priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
			acc_d = {acc_q[27:0], ch[3:0]};
		end else if ((ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
				|| (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F)) begin
			acc_d = {acc_q[27:0], ch[3:0] + 4'd9};
		end else if (ch == CHAR_HASH) begin
			data_d = acc_q;
			acc_d  = '0;
		end else if (ch == CHAR_BANG) begin
			sel_d = |acc_q;
			acc_d = '0;
		end else if (ch == CHAR_EQUAL) begin
			push_cmd.kind = ACT_PINS;
			push_cmd.rst  = acc_q[0];
			push_cmd.clk  = acc_q[1];
			push_cmd.dat  = acc_q[2];
			acc_d         = '0;
		end else if (ch == CHAR_GREATER) begin
			push_cmd.kind   = ACT_SHIFT_OUT;
			push_cmd.word   = data_q;
			push_cmd.length = acc_q[5:0];
			acc_d           = '0;
		end else if (ch == CHAR_LESS) begin
			push_cmd.kind   = ACT_SHIFT_IN;
			push_cmd.word   = captured;
			push_cmd.length = {1'b0, len5};
			if (acc_q > 32'd16) begin
				push_cmd.digits = DIGITS_WORD;
			end else if (acc_q > 32'd8) begin
				push_cmd.digits = DIGITS_HALF;
			end else begin
				push_cmd.digits = DIGITS_BYTE;
			end
			data_d = captured;
			acc_d  = '0;
		end else if (ch == CHAR_DOT) begin
			push_c = 1'b0;
		end else begin
			push_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			data_q <= '0;
			sel_q  <= 1'b0;
		end else if (accept) begin
			acc_q  <= acc_d;
			data_q <= data_d;
			sel_q  <= sel_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hcsb_queue.sv -----
// Short command queue between the front end and the result sequencer.
`default_nettype none

module hcsb_queue
	import hcsb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hcsb_back.sv -----
// Back end: expands each queued command into its results and holds them in the output register.
`default_nettype none

module hcsb_back
	import hcsb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic empty,
	input  wire cmd_t head,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	logic [3:0] step_q;
	logic       out_valid_q;
	result_t    out_q;
	result_t    next_res;
	logic       load;
	logic [3:0] nib_diff;
	logic [2:0] nib_idx;

	assign load         = !empty && (!out_valid_q || !result_stall);
	assign pop          = load && next_res.last;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign nib_diff     = head.digits + 4'd1 - step_q;
	assign nib_idx      = nib_diff[2:0];

	always_comb begin
		next_res = '0;
		if (step_q == 4'd0 && head.kind != ACT_TX) begin
			next_res.action       = head.kind;
			next_res.port_select  = head.port;
			next_res.reset_level  = head.rst;
			next_res.clock_level  = head.clk;
			next_res.data_level   = head.dat;
			next_res.shift_word   = head.word;
			next_res.shift_length = head.length;
		end else if (step_q == 4'd0) begin
			next_res.action  = ACT_TX;
			next_res.tx_char = head.ch;
			next_res.last    = 1'b1;
		end else if (step_q == 4'd1) begin
			next_res.action  = ACT_TX;
			next_res.tx_char = head.ch;
			next_res.last    = (head.kind != ACT_SHIFT_IN);
		end else begin
			next_res.action  = ACT_TX;
			next_res.tx_char = hex_char(head.word[{nib_idx, 2'b00} +: 4]);
			next_res.last    = (nib_diff == 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (!out_valid_q || !result_stall) begin
				out_valid_q <= !empty;
			end
			if (load) begin
				step_q <= next_res.last ? 4'd0 : step_q + 4'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hex_command_serial_shift_bridge.sv -----
// Top level of the hex command shift bridge: front end, command queue and result sequencer.
//
// The bridge takes one received character per cycle as long as its command queue
// (QUEUE_DEPTH entries) has room; period characters take no queue space. The result
// sequencer emits one result per cycle from the head of the queue unless stalled, and
// each character yields its results in turn: one for a plain echo or data command, two
// for pin and shift-out commands, and four, six or ten for a shift-in with its hex report.
// Sustained throughput is therefore set by the sequencer's single output register.
`default_nettype none

module hex_command_serial_shift_bridge
	import hcsb_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	hcsb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	hcsb_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.head     (head),
		.empty    (queue_empty)
	);

	hcsb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (queue_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the hex command serial shift bridge with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
	import hcsb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] CHAR_OPEN_BRACKET = 8'h5B;
	localparam logic [7:0] CHAR_UPPER_S = 8'h53;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_ALL_ONES = 8'hFF;
	localparam int CASE_UPPER = 0;
	localparam int CASE_LOWER = 1;
	localparam int CASE_MIXED = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	logic [31:0] acc_word = '0;
	logic [31:0] data_word_q = '0;
	logic port_q = 1'b0;
	result_t expected_results[$];
	int mismatches = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit quiet_phase = 1'b0;

	hex_command_serial_shift_bridge u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic push_echo(input logic [7:0] ch);
		result_t r;
		r = '0;
		r.action = ACT_TX;
		r.tx_char = ch;
		expected_results.push_back(r);
	endtask

	task automatic predict_item(input item_t it);
		logic [7:0] c;
		logic [7:0] v;
		logic [31:0] a;
		logic [4:0] n;
		logic [3:0] nib;
		result_t r;
		int base;
		int digit_count;
		int i;
		c = it.rx_char;
		a = acc_word;
		base = expected_results.size();
		digit_count = 0;
		r = '0;
		r.port_select = port_q;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			v = c - CHAR_ZERO;
			acc_word = {a[27:0], v[3:0]};
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			v = c - CHAR_UPPER_A + 8'd10;
			acc_word = {a[27:0], v[3:0]};
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
			v = c - CHAR_LOWER_A + 8'd10;
			acc_word = {a[27:0], v[3:0]};
		end else if (c == CHAR_HASH) begin
			data_word_q = a;
			acc_word = '0;
		end else if (c == CHAR_BANG) begin
			port_q = (a != 32'd0);
			acc_word = '0;
		end else if (c == CHAR_EQUAL) begin
			r.action = ACT_PINS;
			r.reset_level = a[0];
			r.clock_level = a[1];
			r.data_level = a[2];
			expected_results.push_back(r);
			acc_word = '0;
		end else if (c == CHAR_GREATER) begin
			r.action = ACT_SHIFT_OUT;
			r.shift_word = data_word_q;
			r.shift_length = a[5:0];
			expected_results.push_back(r);
			acc_word = '0;
		end else if (c == CHAR_LESS) begin
			n = a[4:0];
			data_word_q = it.target_bits & ~(32'hFFFF_FFFF << n);
			r.action = ACT_SHIFT_IN;
			r.shift_word = data_word_q;
			r.shift_length = {1'b0, n};
			expected_results.push_back(r);
			digit_count = (a > 32'd16) ? 8 : (a > 32'd8) ? 4 : 2;
			acc_word = '0;
		end
		if (c != CHAR_DOT) begin
			push_echo(c);
		end
		for (i = digit_count - 1; i >= 0; i--) begin
			nib = data_word_q[4 * i +: 4];
			push_echo(nib < 4'd10 ? CHAR_ZERO + nib : CHAR_UPPER_A + nib - 8'd10);
		end
		if (expected_results.size() > base) begin
			expected_results[expected_results.size() - 1].last = 1'b1;
		end
	endtask

	task automatic send_item(input logic [7:0] ch, input logic [31:0] bits);
		item_t next_item;
		bit taken;
		next_item = '{rx_char: ch, target_bits: bits};
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= next_item;
		do begin
			@(negedge clk);
			taken = !item_stall;
			if (taken) begin
				predict_item(next_item);
			end
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic send_hex(input logic [31:0] value, input int ndig, input int letter_case);
		logic [3:0] nib;
		bit lower;
		int i;
		for (i = ndig - 1; i >= 0; i--) begin
			nib = value[4 * i +: 4];
			lower = (letter_case == CASE_MIXED) ? 1'($urandom_range(0, 1))
				: (letter_case == CASE_LOWER);
			if (nib < 4'd10) begin
				send_item(CHAR_ZERO + nib, $urandom);
			end else begin
				send_item((lower ? CHAR_LOWER_A : CHAR_UPPER_A) + nib - 8'd10, $urandom);
			end
		end
	endtask

	task automatic test_hex_digits;
		send_hex(32'h09AF, 4, CASE_UPPER);
		send_hex(32'h00AF, 2, CASE_LOWER);
		send_item(CHAR_HASH, $urandom);
	endtask

	task automatic test_pin_levels;
		send_hex(32'h1, 1, CASE_UPPER);
		send_item(CHAR_BANG, $urandom);
		send_hex(32'h7, 1, CASE_UPPER);
		send_item(CHAR_EQUAL, $urandom);
		send_item(CHAR_BANG, $urandom);
		send_item(CHAR_EQUAL, $urandom);
	endtask

	task automatic test_shift_out;
		send_hex(32'h3F, 2, CASE_UPPER);
		send_item(CHAR_GREATER, $urandom);
		send_item(CHAR_GREATER, $urandom);
	endtask

	task automatic test_shift_in;
		send_hex(32'h1F, 2, CASE_UPPER);
		send_item(CHAR_LESS, 32'hFFFF_FFFF);
		send_hex(32'h9, 1, CASE_UPPER);
		send_item(CHAR_LESS, 32'hFFFF_FFFF);
		send_hex(32'h8, 1, CASE_UPPER);
		send_item(CHAR_LESS, 32'h8000_00FF);
		send_item(CHAR_LESS, 32'hFFFF_FFFF);
	endtask

	task automatic test_ignored_chars;
		send_item(CHAR_DOT, $urandom);
		send_item(CHAR_OPEN_BRACKET, $urandom);
		send_item(CHAR_NUL, 32'h0000_0000);
		send_item(CHAR_ALL_ONES, 32'hFFFF_FFFF);
	endtask

	task automatic send_command_sequence;
		logic [7:0] commands[6];
		int ndig;
		commands = '{CHAR_HASH, CHAR_BANG, CHAR_EQUAL, CHAR_GREATER, CHAR_LESS, CHAR_LESS};
		ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
		send_hex($urandom, ndig, CASE_MIXED);
		if ($urandom_range(0, 9) == 0) begin
			send_item(CHAR_DOT, $urandom);
		end
		send_item(commands[$urandom_range(0, 5)],
			($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
	endtask

	task automatic test_random_commands;
		while (items_sent < 200) begin
			send_command_sequence();
		end
	endtask

	task automatic test_random_noise;
		while (items_sent < 235) begin
			case ($urandom_range(0, 3))
				0, 1: send_item(8'($urandom_range(0, 255)), $urandom);
				2: begin
					send_hex($urandom, $urandom_range(1, 3), CASE_MIXED);
					send_item(8'($urandom_range(0, 255)), $urandom);
				end
				default: send_item($urandom_range(0, 1) ? CHAR_UPPER_S : CHAR_DOT, $urandom);
			endcase
		end
	endtask

	task automatic test_back_to_back;
		quiet_phase = 1'b1;
		while (items_sent < 275) begin
			send_command_sequence();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 16);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(negedge clk) begin
		result_t exp;
		string bad;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result transaction: %p", result);
				end
			end else begin
				exp = expected_results.pop_front();
				bad = "";
				if (result.action !== exp.action) bad = {bad, " action"};
				if (result.tx_char !== exp.tx_char) bad = {bad, " tx_char"};
				if (result.port_select !== exp.port_select) bad = {bad, " port_select"};
				if (result.reset_level !== exp.reset_level) bad = {bad, " reset_level"};
				if (result.clock_level !== exp.clock_level) bad = {bad, " clock_level"};
				if (result.data_level !== exp.data_level) bad = {bad, " data_level"};
				if (result.shift_word !== exp.shift_word) bad = {bad, " shift_word"};
				if (result.shift_length !== exp.shift_length) bad = {bad, " shift_length"};
				if (result.last !== exp.last) bad = {bad, " last"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch in%s: expected %p, got %p", bad, exp, result);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles.", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hex_digits();
		test_pin_levels();
		test_shift_out();
		test_shift_in();
		test_ignored_chars();
		test_random_commands();
		test_random_noise();
		test_back_to_back();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- hex_command_serial_shift_bridge.f -----
rtl/core/hcsb_pkg.sv
rtl/core/hcsb_front.sv
rtl/core/hcsb_queue.sv
rtl/core/hcsb_back.sv
rtl/core/hex_command_serial_shift_bridge.sv
verif/tb_top.sv
